// File: rtl/cru_pkg.sv
// ----------------------------------------------------------------------------
// cru_pkg
// shared types and constants of the catmull-rom bicubic upsampler
// ----------------------------------------------------------------------------
package cru_pkg;

  localparam int COORD_W  = 10;
  localparam int DIM_W    = 9;
  localparam int FACT_W   = 5;
  localparam int FACT_MAX = 16;
  localparam int LARGE_W  = 14;
  localparam int CFG_W    = 7;
  localparam int IDX_W    = 2;
  localparam int WT_W     = 16;
  localparam int DEN_W    = 27;

  localparam logic [IDX_W-1:0] REG_WIDTH  = 2'd0;
  localparam logic [IDX_W-1:0] REG_HEIGHT = 2'd1;
  localparam logic [IDX_W-1:0] REG_FACTOR = 2'd2;

  typedef enum logic [1:0] {
    K_LOAD  = 2'd0,
    K_QUERY = 2'd1,
    K_OOR   = 2'd2
  } kind_t;

  typedef struct packed {
    kind_t              kind;
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
  } q_meta_t;

  typedef struct packed {
    logic [DIM_W-1:0]  w;
    logic [DIM_W-1:0]  h;
    logic [FACT_W-1:0] f;
  } cfg_t;

  typedef struct packed {
    logic pop;
    logic busy;
  } bk_stat_t;

  typedef logic signed [WT_W-1:0] wt_t;

  // catmull-rom weight idx for t=r/f, scaled by 2f^3
  function automatic wt_t cr_wt(input logic [1:0] idx, input logic [11:0] rf2,
                                input logic [11:0] r2f, input logic [11:0] r3,
                                input logic [12:0] f3);
    wt_t a;
    wt_t b;
    wt_t c;
    wt_t d;
    wt_t res;
    a = wt_t'({4'b0, rf2});
    b = wt_t'({4'b0, r2f});
    c = wt_t'({4'b0, r3});
    d = wt_t'({3'b0, f3});
    case (idx)
      2'd0:    res = -a + (b <<< 1) - c;
      2'd1:    res = (d <<< 1) - (b <<< 2) - b + (c <<< 1) + c;
      2'd2:    res = a + (b <<< 2) - (c <<< 1) - c;
      default: res = c - b;
    endcase
    return res;
  endfunction

endpackage

// File: rtl/cru_queue.sv
// ----------------------------------------------------------------------------
// cru_queue
// two-entry queue between the classifier and the compute engine
// ----------------------------------------------------------------------------
module cru_queue #(
  parameter int DW = 8
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  logic [DW-1:0] wdata,
  output logic          full,
  output logic          valid,
  output logic [DW-1:0] rdata,
  input  logic          pop
);

  logic [DW-1:0] ent [2];
  logic          wr_ptr;
  logic          rd_ptr;
  logic [1:0]    count;

  assign full  = (count == 2'd2);
  assign valid = (count != 2'd0);
  assign rdata = ent[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      ent[wr_ptr] <= wdata;
    end
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

// File: rtl/cru_front.sv
// ----------------------------------------------------------------------------
// cru_front
// register file, input acceptance and classification of transactions
// ----------------------------------------------------------------------------
module cru_front import cru_pkg::*; #(
  parameter int MAX_DIM = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_wr_en,
  input  logic [IDX_W-1:0]   cfg_index,
  input  logic [CFG_W-1:0]   cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               func,
  input  logic [COORD_W-1:0] col,
  input  logic [COORD_W-1:0] row,
  output logic               push,
  output q_meta_t            push_meta,
  input  logic               q_full,
  output cfg_t               cfg
);

  logic [CFG_W-1:0]   width_raw;
  logic [CFG_W-1:0]   height_raw;
  logic [FACT_W-1:0]  upsample_factor;
  logic [LARGE_W-1:0] large_w;
  logic [LARGE_W-1:0] large_h;
  logic [DIM_W-1:0]   w_next;
  logic [DIM_W-1:0]   h_next;
  logic [FACT_W-1:0]  f_next;
  logic               in_store;
  logic               out_range;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [CFG_W-1:0] v);
    logic [DIM_W-1:0] x;
    x = DIM_W'(v);
    if (x < DIM_W'(2)) begin
      x = DIM_W'(2);
    end else if (x > DIM_W'(MAX_DIM)) begin
      x = DIM_W'(MAX_DIM);
    end
    return x;
  endfunction

  always_comb begin
    w_next = clamp_dim(width_raw);
    h_next = clamp_dim(height_raw);
    if (upsample_factor < FACT_W'(2)) begin
      f_next = FACT_W'(2);
    end else if (upsample_factor > FACT_W'(FACT_MAX)) begin
      f_next = FACT_W'(FACT_MAX);
    end else begin
      f_next = upsample_factor;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      width_raw       <= CFG_W'(24);
      height_raw      <= CFG_W'(24);
      upsample_factor <= FACT_W'(2);
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_WIDTH:  width_raw       <= cfg_data;
        REG_HEIGHT: height_raw      <= cfg_data;
        REG_FACTOR: upsample_factor <= cfg_data[FACT_W-1:0];
        default: ;
      endcase
    end
    // derived geometry, settles in the cycle after a register write
    cfg.w   <= w_next;
    cfg.h   <= h_next;
    cfg.f   <= f_next;
    large_w <= LARGE_W'(f_next) * LARGE_W'(w_next - DIM_W'(1)) + LARGE_W'(1);
    large_h <= LARGE_W'(f_next) * LARGE_W'(h_next - DIM_W'(1)) + LARGE_W'(1);
  end

  assign in_store  = (DIM_W'(col) < DIM_W'(MAX_DIM)) && (col < COORD_W'(MAX_DIM))
                     && (DIM_W'(row) < DIM_W'(MAX_DIM)) && (row < COORD_W'(MAX_DIM));
  assign out_range = (LARGE_W'(col) >= large_w) || (LARGE_W'(row) >= large_h);

  assign in_stall = q_full;

  // loads outside the store are dropped here
  assign push = in_valid && !q_full && (func || in_store);

  always_comb begin
    push_meta.col = col;
    push_meta.row = row;
    if (!func) begin
      push_meta.kind = K_LOAD;
    end else if (out_range) begin
      push_meta.kind = K_OOR;
    end else begin
      push_meta.kind = K_QUERY;
    end
  end

endmodule

// File: rtl/cru_back.sv
// ----------------------------------------------------------------------------
// cru_back
// sample store, interpolation sequencer and output register
// ----------------------------------------------------------------------------
module cru_back import cru_pkg::*; #(
  parameter int MAX_DIM     = 64,
  parameter int SAMPLE_BITS = 24
) (
  input  logic                          clk,
  input  logic                          rst,
  input  cfg_t                          cfg,
  input  logic                          q_valid,
  input  q_meta_t                       q_meta,
  input  logic signed [SAMPLE_BITS-1:0] q_sample,
  output bk_stat_t                      stat,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [SAMPLE_BITS-1:0] pixel_value,
  output logic                          status
);

  localparam int SB     = SAMPLE_BITS;
  localparam int AW     = $clog2(MAX_DIM);
  localparam int DEPTH  = MAX_DIM * MAX_DIM;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int PROD_W = SB + WT_W;
  localparam int RS_W   = SB + WT_W + 2;
  localparam int LO_W   = 25;
  localparam int P2_W   = WT_W + LO_W + 1;
  localparam int ACC_W  = RS_W + WT_W + 2;
  localparam int XW     = COORD_W + 2;

  typedef enum logic [11:0] {
    S_IDLE  = 12'b000000000001,
    S_DIV   = 12'b000000000010,
    S_WT1   = 12'b000000000100,
    S_WT2   = 12'b000000001000,
    S_WT3   = 12'b000000010000,
    S_FETCH = 12'b000000100000,
    S_COL   = 12'b000001000000,
    S_RND   = 12'b000010000000,
    S_CHK   = 12'b000100000000,
    S_QDIV  = 12'b001000000000,
    S_SAT   = 12'b010000000000,
    S_DONE  = 12'b100000000000
  } state_t;

  state_t state;

  logic [SB-1:0]            mem [DEPTH];
  logic signed [SB-1:0]     rd_data;
  logic [ADDR_W-1:0]        rd_addr;
  logic [ADDR_W-1:0]        wr_addr;
  logic                     mem_we;

  logic [COORD_W-1:0]       qx;
  logic [COORD_W-1:0]       qy;
  logic [FACT_W-1:0]        remx;
  logic [FACT_W-1:0]        remy;
  logic [3:0]               dcnt;
  logic [FACT_W:0]          tx;
  logic [FACT_W:0]          ty;
  logic                     gex;
  logic                     gey;

  logic [8:0]               f2;
  logic [7:0]               rx2;
  logic [7:0]               ry2;
  logic [12:0]              f3;
  logic [11:0]              rx3;
  logic [11:0]              ry3;
  logic [11:0]              rxf2;
  logic [11:0]              ryf2;
  logic [11:0]              rx2f;
  logic [11:0]              ry2f;
  wt_t                      wx [4];
  wt_t                      wy [4];
  logic [DEN_W-1:0]         den;

  logic [4:0]               k;
  logic [3:0]               k_d1;
  logic [3:0]               k_d2;
  logic                     v1;
  logic                     v2;
  logic signed [PROD_W-1:0] prod;
  logic signed [RS_W-1:0]   rsum [4];
  logic signed [XW-1:0]     xs;
  logic signed [XW-1:0]     ys;
  logic [AW-1:0]            xc;
  logic [AW-1:0]            yc;

  logic [3:0]               c;
  logic signed [RS_W-1:0]   rs_sel;
  logic signed [LO_W:0]     opnd;
  logic signed [P2_W-1:0]   prod2;
  logic                     p2v;
  logic                     p2hi;
  logic signed [ACC_W-1:0]  acc;

  logic                     neg;
  logic [ACC_W-1:0]         nmag;
  logic [DEN_W-1:0]         rem;
  logic [SB-1:0]            nlow;
  logic [DEN_W:0]           tq;
  logic                     geq;
  logic [$clog2(SB)-1:0]    qcnt;
  logic [SB-1:0]            res;
  logic                     st_hold;

  assign stat.pop  = (state == S_IDLE) && q_valid;
  assign stat.busy = (state != S_IDLE);

  assign mem_we  = stat.pop && (q_meta.kind == K_LOAD);
  assign wr_addr = ADDR_W'(q_meta.row) * ADDR_W'(MAX_DIM) + ADDR_W'(q_meta.col);

  // tap address with edge clamping
  always_comb begin
    xs = $signed(XW'(qx) + XW'(k[1:0])) - XW'(1);
    ys = $signed(XW'(qy) + XW'(k[3:2])) - XW'(1);
    if (xs < 0) begin
      xc = '0;
    end else if (xs > $signed(XW'(cfg.w)) - XW'(1)) begin
      xc = AW'(cfg.w - DIM_W'(1));
    end else begin
      xc = AW'(xs);
    end
    if (ys < 0) begin
      yc = '0;
    end else if (ys > $signed(XW'(cfg.h)) - XW'(1)) begin
      yc = AW'(cfg.h - DIM_W'(1));
    end else begin
      yc = AW'(ys);
    end
    rd_addr = ADDR_W'(yc) * ADDR_W'(MAX_DIM) + ADDR_W'(xc);
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= q_sample;
    end
    rd_data <= mem[rd_addr];
  end

  always_comb begin
    tx  = {remx, qx[COORD_W-1]};
    ty  = {remy, qy[COORD_W-1]};
    gex = (tx >= {1'b0, cfg.f});
    gey = (ty >= {1'b0, cfg.f});
    rs_sel = rsum[c[2:1]];
    if (c[0]) begin
      opnd = (LO_W+1)'($signed(rs_sel[RS_W-1:LO_W]));
    end else begin
      opnd = $signed({1'b0, rs_sel[LO_W-1:0]});
    end
    nmag = acc[ACC_W-1] ? ~acc : acc;
    tq   = {rem, nlow[SB-1]};
    geq  = (tq >= {1'b0, den});
  end

  always_ff @(posedge clk) begin
    // tap pipeline: read, weight, row sum
    v1   <= (state == S_FETCH) && !k[4];
    k_d1 <= k[3:0];
    v2   <= v1;
    k_d2 <= k_d1;
    prod <= wx[k_d1[1:0]] * rd_data;
    if (v2) begin
      if (k_d2[1:0] == 2'd0) begin
        rsum[k_d2[3:2]] <= RS_W'(prod);
      end else begin
        rsum[k_d2[3:2]] <= rsum[k_d2[3:2]] + RS_W'(prod);
      end
    end
    if (p2v) begin
      if (p2hi) begin
        acc <= acc + (ACC_W'(prod2) <<< LO_W);
      end else begin
        acc <= acc + ACC_W'(prod2);
      end
    end
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      p2v       <= 1'b0;
    end else begin
      p2v <= 1'b0;
      // the done state reloads the output register itself
      if (out_valid && !out_stall && (state != S_DONE)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (q_valid) begin
            case (q_meta.kind)
              K_QUERY: begin
                qx    <= q_meta.col;
                qy    <= q_meta.row;
                remx  <= '0;
                remy  <= '0;
                dcnt  <= 4'd9;
                state <= S_DIV;
              end
              K_OOR: begin
                res     <= '0;
                st_hold <= 1'b1;
                state   <= S_DONE;
              end
              default: ;
            endcase
          end
        end
        S_DIV: begin
          // one quotient bit per cycle for both coordinates
          remx <= gex ? FACT_W'(tx - {1'b0, cfg.f}) : tx[FACT_W-1:0];
          remy <= gey ? FACT_W'(ty - {1'b0, cfg.f}) : ty[FACT_W-1:0];
          qx   <= {qx[COORD_W-2:0], gex};
          qy   <= {qy[COORD_W-2:0], gey};
          dcnt <= dcnt - 4'd1;
          if (dcnt == 4'd0) begin
            state <= S_WT1;
          end
        end
        S_WT1: begin
          f2    <= 9'(cfg.f) * 9'(cfg.f);
          rx2   <= 8'(remx[3:0]) * 8'(remx[3:0]);
          ry2   <= 8'(remy[3:0]) * 8'(remy[3:0]);
          state <= S_WT2;
        end
        S_WT2: begin
          f3    <= 13'(f2) * 13'(cfg.f);
          rx3   <= 12'(rx2) * 12'(remx[3:0]);
          ry3   <= 12'(ry2) * 12'(remy[3:0]);
          rxf2  <= 12'(f2) * 12'(remx[3:0]);
          ryf2  <= 12'(f2) * 12'(remy[3:0]);
          rx2f  <= 12'(rx2) * 12'(cfg.f);
          ry2f  <= 12'(ry2) * 12'(cfg.f);
          state <= S_WT3;
        end
        S_WT3: begin
          for (int n = 0; n < 4; n++) begin
            wx[n] <= cr_wt(2'(n), rxf2, rx2f, rx3, f3);
            wy[n] <= cr_wt(2'(n), ryf2, ry2f, ry3, f3);
          end
          den   <= {25'(f3) * 25'(f3), 2'b00};
          acc   <= '0;
          k     <= '0;
          state <= S_FETCH;
        end
        S_FETCH: begin
          k <= k + 5'd1;
          if (k == 5'd17) begin
            c     <= '0;
            state <= S_COL;
          end
        end
        S_COL: begin
          // low and high halves of each row sum through one multiplier
          if (!c[3]) begin
            prod2 <= wy[c[2:1]] * opnd;
            p2v   <= 1'b1;
            p2hi  <= c[0];
            c     <= c + 4'd1;
          end else begin
            state <= S_RND;
          end
        end
        S_RND: begin
          acc   <= acc + $signed(ACC_W'(den >> 1));
          state <= S_CHK;
        end
        S_CHK: begin
          neg <= acc[ACC_W-1];
          if (nmag >= (ACC_W'(den) << SB)) begin
            nlow  <= '1;
            state <= S_SAT;
          end else begin
            rem   <= DEN_W'(nmag >> SB);
            nlow  <= nmag[SB-1:0];
            qcnt  <= ($clog2(SB))'(SB - 1);
            state <= S_QDIV;
          end
        end
        S_QDIV: begin
          rem  <= geq ? DEN_W'(tq - {1'b0, den}) : tq[DEN_W-1:0];
          nlow <= {nlow[SB-2:0], geq};
          qcnt <= qcnt - 1'b1;
          if (qcnt == '0) begin
            state <= S_SAT;
          end
        end
        S_SAT: begin
          // floor of a negative value comes out as the complement
          if (nlow[SB-1]) begin
            res <= neg ? {1'b1, {(SB-1){1'b0}}} : {1'b0, {(SB-1){1'b1}}};
          end else begin
            res <= neg ? ~nlow : nlow;
          end
          st_hold <= 1'b0;
          state   <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid || !out_stall) begin
            pixel_value <= res;
            status      <= st_hold;
            out_valid   <= 1'b1;
            state       <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// File: rtl/catmull_rom_bicubic_upsampler.sv
// ----------------------------------------------------------------------------
// catmull_rom_bicubic_upsampler
// integer-factor catmull-rom bicubic upscaler over a stored small image
// ----------------------------------------------------------------------------
//  channel | handshake              | payload
//  --------+------------------------+-----------------------------------
//  in      | in_valid / in_stall    | func, col, row, sample
//  out     | out_valid / out_stall  | pixel_value, status
//  cfg     | cfg_wr_en              | cfg_index, cfg_data
//
//  a query runs in the compute engine through coordinate division, sixteen store
//  reads through one read port, eight column multiplies and a one-bit-per-cycle
//  final division; a load is written to the store from the idle state.
//  a two-entry queue lets the input side keep taking transactions meanwhile.
//  reset is synchronous; the sample store is not cleared and holds garbage
//  until loaded. a stalled result waits in the output register.
// ----------------------------------------------------------------------------
module catmull_rom_bicubic_upsampler import cru_pkg::*; #(
  parameter int MAX_DIM     = 64,
  parameter int SAMPLE_BITS = 24
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_wr_en,
  input  logic [IDX_W-1:0]              cfg_index,
  input  logic [CFG_W-1:0]              cfg_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          func,
  input  logic [COORD_W-1:0]            col,
  input  logic [COORD_W-1:0]            row,
  input  logic signed [SAMPLE_BITS-1:0] sample,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [SAMPLE_BITS-1:0] pixel_value,
  output logic                          status
);

  localparam int QW = $bits(q_meta_t) + SAMPLE_BITS;

  logic             push;
  q_meta_t          push_meta;
  logic             q_full;
  logic             q_valid;
  logic [QW-1:0]    q_rdata;
  q_meta_t          q_meta;
  logic [SAMPLE_BITS-1:0] q_sample;
  cfg_t             cfg;
  bk_stat_t         stat;

  cru_front #(
    .MAX_DIM(MAX_DIM)
  ) u_front (
    .clk(clk),
    .rst(rst),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .func(func),
    .col(col),
    .row(row),
    .push(push),
    .push_meta(push_meta),
    .q_full(q_full),
    .cfg(cfg)
  );

  cru_queue #(
    .DW(QW)
  ) u_queue (
    .clk(clk),
    .rst(rst),
    .push(push),
    .wdata({push_meta, sample}),
    .full(q_full),
    .valid(q_valid),
    .rdata(q_rdata),
    .pop(stat.pop)
  );

  assign q_meta   = q_rdata[QW-1:SAMPLE_BITS];
  assign q_sample = q_rdata[SAMPLE_BITS-1:0];

  cru_back #(
    .MAX_DIM(MAX_DIM),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_back (
    .clk(clk),
    .rst(rst),
    .cfg(cfg),
    .q_valid(q_valid),
    .q_meta(q_meta),
    .q_sample($signed(q_sample)),
    .stat(stat),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .pixel_value(pixel_value),
    .status(status)
  );

  a_oor_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status |-> pixel_value == '0)
    else $error("out-of-range result carries a nonzero value");

  a_pop_valid: assert property (@(posedge clk) disable iff (rst)
    stat.pop |-> q_valid && !stat.busy)
    else $error("engine took from an empty queue or while busy");

  a_reset_clear: assert property (@(posedge clk)
    rst |=> !out_valid && !q_valid)
    else $error("output or queue not empty after reset");

endmodule

// File: sim/catmull_rom_bicubic_upsampler_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// catmull_rom_bicubic_upsampler_tb
// drives load and query transactions through several image and factor
// settings, predicts every interpolated pixel and checks the results in order
// ----------------------------------------------------------------------------
module catmull_rom_bicubic_upsampler_tb;
  import cru_pkg::*;

  localparam logic FUNC_LOAD  = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;
  localparam int   STORE_DIM  = 64;
  localparam int   SETTLE     = 150;
  localparam int   CYCLE_LIMIT = 1500000;

  class upsample_scoreboard;
    logic signed [23:0] samples [STORE_DIM*STORE_DIM];
    bit                 written [STORE_DIM*STORE_DIM];
    logic [6:0]         width_reg;
    logic [6:0]         height_reg;
    logic [4:0]         factor_reg;
    logic signed [23:0] pixel_q [$];
    logic               status_q [$];
    int                 errors;

    function void clear();
      foreach (written[i]) written[i] = 0;
      width_reg = 24;
      height_reg = 24;
      factor_reg = 2;
      errors = 0;
    endfunction

    function void write_reg(logic [IDX_W-1:0] idx, logic [6:0] data);
      case (idx)
        REG_WIDTH:  width_reg = data;
        REG_HEIGHT: height_reg = data;
        REG_FACTOR: factor_reg = data[4:0];
        default: ;
      endcase
    endfunction

    function int used_w();
      return width_reg < 2 ? 2 : (width_reg > STORE_DIM ? STORE_DIM : width_reg);
    endfunction

    function int used_h();
      return height_reg < 2 ? 2 : (height_reg > STORE_DIM ? STORE_DIM : height_reg);
    endfunction

    function int used_f();
      return factor_reg < 2 ? 2 : (factor_reg > FACT_MAX ? FACT_MAX : factor_reg);
    endfunction

    function longint weight(int k, longint r, longint f);
      case (k)
        0:       return -r*f*f + 2*r*r*f - r*r*r;
        1:       return 2*f*f*f - 5*r*r*f + 3*r*r*r;
        2:       return r*f*f + 4*r*r*f - 3*r*r*r;
        default: return -r*r*f + r*r*r;
      endcase
    endfunction

    function longint stored(int x, int y, int w, int h);
      x = x < 0 ? 0 : (x > w-1 ? w-1 : x);
      y = y < 0 ? 0 : (y > h-1 ? h-1 : y);
      return samples[y*STORE_DIM + x];
    endfunction

    function void note_input(logic fn, logic [9:0] c, logic [9:0] r,
                             logic signed [23:0] s);
      int w, h, f, sx, sy;
      longint acc, rsum, den, q;
      w = used_w();
      h = used_h();
      f = used_f();
      if (fn == FUNC_LOAD) begin
        if (c < STORE_DIM && r < STORE_DIM) begin
          samples[r*STORE_DIM + c] = s;
          written[r*STORE_DIM + c] = 1;
        end
        return;
      end
      if (c >= f*(w-1)+1 || r >= f*(h-1)+1) begin
        pixel_q.insert(pixel_q.size(), '0);
        status_q.insert(status_q.size(), 1'b1);
        return;
      end
      sx = c / f;
      sy = r / f;
      acc = 0;
      for (int i = 0; i < 4; i++) begin
        rsum = 0;
        for (int j = 0; j < 4; j++)
          rsum += weight(j, c % f, f) * stored(sx-1+j, sy-1+i, w, h);
        acc += weight(i, r % f, f) * rsum;
      end
      den = 4*longint'(f)*f*f*f*f*f;
      acc += den / 2;
      q = acc / den;
      if (acc % den != 0 && acc < 0) q -= 1;
      if (q > 8388607) q = 8388607;
      if (q < -8388608) q = -8388608;
      pixel_q.insert(pixel_q.size(), q[23:0]);
      status_q.insert(status_q.size(), 1'b0);
    endfunction

    function void check_result(logic signed [23:0] pix, logic st);
      logic signed [23:0] ep;
      logic es;
      if (pixel_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result: pixel %0d status %0d", pix, st);
        return;
      end
      ep = pixel_q.pop_front();
      es = status_q.pop_front();
      if (pix !== ep || st !== es) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: expected pixel %0d status %0d, got pixel %0d status %0d",
                   ep, es, pix, st);
      end
    endfunction
  endclass

  logic               clk;
  logic               rst;
  logic               cfg_wr_en;
  logic [IDX_W-1:0]   cfg_index;
  logic [CFG_W-1:0]   cfg_data;
  logic               in_valid;
  logic               in_stall;
  logic               func;
  logic [COORD_W-1:0] col;
  logic [COORD_W-1:0] row;
  logic signed [23:0] sample;
  logic               out_valid;
  logic               out_stall;
  logic signed [23:0] pixel_value;
  logic               status;

  upsample_scoreboard sb;
  bit  calm;
  int  stall_left;
  int  cycles;

  catmull_rom_bicubic_upsampler dut (
    .clk(clk), .rst(rst),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .func(func), .col(col), .row(row), .sample(sample),
    .out_valid(out_valid), .out_stall(out_stall),
    .pixel_value(pixel_value), .status(status)
  );

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // receiver stall: mostly short bursts, now and then a long one
  always @(posedge clk) begin : stall_gen
    int r;
    r = $urandom_range(0, 99);
    if (rst || calm) begin
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (r < 25) begin
      out_stall <= 1'b1;
      stall_left <= (r < 3) ? $urandom_range(10, 40) : $urandom_range(0, 3);
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) sb.check_result(pixel_value, status);
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // extremes often, so that overshoot runs into saturation
  function automatic logic signed [23:0] pick_sample();
    int r;
    r = $urandom_range(0, 99);
    if (r < 25) return 24'sh7fffff;
    if (r < 50) return 24'sh800000;
    return 24'($urandom());
  endfunction

  task automatic send(logic fn, int c, int r, logic signed [23:0] s);
    int gap;
    in_valid <= 1'b1;
    func <= fn;
    col <= c[9:0];
    row <= r[9:0];
    sample <= s;
    do @(posedge clk); while (in_stall);
    sb.note_input(fn, c[9:0], r[9:0], s);
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain();
    while (sb.pixel_q.size() > 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // registers change only once the block has gone quiet
  task automatic configure(int w_raw, int h_raw, int f_raw);
    in_valid <= 1'b0;
    drain();
    cfg_wr_en <= 1'b1;
    cfg_index <= REG_WIDTH;
    cfg_data <= w_raw[6:0];
    @(posedge clk);
    sb.write_reg(REG_WIDTH, w_raw[6:0]);
    cfg_index <= REG_HEIGHT;
    cfg_data <= h_raw[6:0];
    @(posedge clk);
    sb.write_reg(REG_HEIGHT, h_raw[6:0]);
    cfg_index <= REG_FACTOR;
    cfg_data <= f_raw[6:0];
    @(posedge clk);
    sb.write_reg(REG_FACTOR, f_raw[6:0]);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  // every sample a query may read has to be loaded first
  task automatic fill_image();
    for (int y = 0; y < sb.used_h(); y++)
      for (int x = 0; x < sb.used_w(); x++)
        if (!sb.written[y*STORE_DIM + x]) send(FUNC_LOAD, x, y, pick_sample());
  endtask

  task automatic random_items(int n);
    int r, lw, lh;
    lw = sb.used_f()*(sb.used_w()-1) + 1;
    lh = sb.used_f()*(sb.used_h()-1) + 1;
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(0, 99);
      if (r < 8)
        send(FUNC_LOAD, $urandom_range(0, sb.used_w()-1), $urandom_range(0, sb.used_h()-1),
             pick_sample());
      else if (r < 11)
        send(FUNC_LOAD, $urandom_range(0, 1023), $urandom_range(0, 1023), 24'($urandom()));
      else if (r < 16)
        send(FUNC_QUERY, $urandom_range(lw, 1023), $urandom_range(0, 1023),
             24'($urandom()));
      else if (r < 21)
        send(FUNC_QUERY, $urandom_range(0, 1023), $urandom_range(lh, 1023),
             24'($urandom()));
      else
        send(FUNC_QUERY, $urandom_range(0, lw-1), $urandom_range(0, lh-1),
             24'($urandom()));
    end
  endtask

  initial begin
    sb = new();
    sb.clear();
    calm = 1'b0;
    stall_left = 0;
    cycles = 0;
    rst = 1'b1;
    cfg_wr_en = 1'b0;
    cfg_index = REG_WIDTH;
    cfg_data = '0;
    in_valid = 1'b0;
    func = FUNC_LOAD;
    col = '0;
    row = '0;
    sample = '0;
    out_stall = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // wide and flat image at the largest factor
    configure(64, 2, 16);
    fill_image();
    send(FUNC_QUERY, 0, 0, 0);
    send(FUNC_QUERY, 1008, 16, 0);
    send(FUNC_QUERY, 1009, 0, 0);
    send(FUNC_QUERY, 0, 17, 0);
    send(FUNC_QUERY, 1023, 1023, 24'sh7fffff);
    send(FUNC_QUERY, 504, 8, 24'sh800000);
    send(FUNC_QUERY, 15, 15, 0);
    send(FUNC_LOAD, 1023, 1023, 24'sh123456);
    send(FUNC_LOAD, 63, 63, 24'sh7fffff);
    send(FUNC_LOAD, 64, 0, 24'sh800000);
    send(FUNC_QUERY, 17, 1, 0);

    // tall and narrow at the smallest factor
    configure(2, 64, 2);
    fill_image();
    send(FUNC_QUERY, 0, 0, 0);
    send(FUNC_QUERY, 2, 126, 0);
    send(FUNC_QUERY, 3, 0, 0);
    send(FUNC_QUERY, 1, 127, 0);
    send(FUNC_QUERY, 1, 63, 0);

    // register values outside the meaningful range
    configure(0, 1, 0);
    send(FUNC_QUERY, 1, 1, 0);
    send(FUNC_QUERY, 2, 2, 0);
    configure(127, 3, 31);
    fill_image();
    send(FUNC_QUERY, 1008, 32, 0);
    send(FUNC_QUERY, 517, 21, 0);
    configure(5, 5, 127);
    fill_image();
    random_items(40);

    for (int p = 0; p < 14; p++) begin
      calm = ($urandom_range(0, 3) == 0);
      configure($urandom_range(2, 12), $urandom_range(2, 12), $urandom_range(2, 16));
      fill_image();
      random_items(25);
    end
    calm = 1'b0;

    in_valid <= 1'b0;
    drain();
    if (sb.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
